>>> rtl/core/pb_pkg.sv
// shared types and constants for the projection bands block
package pb_pkg;

	localparam int PB_MAX_PERIOD = 64;
	localparam int PRICE_W = 31;
	localparam int BAND_W = 48;
	localparam int PERIOD_W = 7;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd14;

	typedef struct packed {
		logic [PRICE_W-1:0] high;
		logic [PRICE_W-1:0] low;
		logic [PRICE_W-1:0] close;
	} pb_bar_t;

	typedef struct packed {
		logic cfg_wr;
		logic accept;
		logic calc_num;
		logic calc_den;
		logic div_start;
		logic walk_init;
		logic walk;
		logic fin;
	} pb_cmd_t;

	typedef struct packed {
		logic warm_done;
		logic div_done;
		logic walk_done;
		logic out_free;
	} pb_stat_t;

endpackage

>>> rtl/core/pb_div.sv
// restoring unsigned divider, one quotient bit per cycle
module pb_div import pb_pkg::*; #(
	parameter int NW = 49,
	parameter int DW = 21
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] sh_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          qbit;
	logic [DW:0]   diff;

	always_comb begin
		trial = {rem_q, sh_q[NW-1]};
		diff  = trial - {1'b0, divisor};
		qbit  = (trial >= {1'b0, divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[NW-2:0], qbit};
			rem_q <= qbit ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

endmodule

>>> rtl/core/pb_ctrl.sv
// sequencing state machine for the projection bands block
module pb_ctrl import pb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     cfg_valid,
	input  pb_stat_t st,
	output logic     in_stall,
	output logic     cfg_ready,
	output pb_cmd_t  cmd
);

	typedef enum logic [2:0] {
		IDLE, NUM, DEN, DIV_GO, DIV_WAIT, WALK_INIT, WALK, FIN
	} state_t;

	state_t state_q;
	logic   idle;
	logic   acc;

	assign idle      = (state_q == IDLE);
	assign cfg_ready = idle;
	assign in_stall  = !idle || cfg_valid;
	assign acc       = in_valid && !in_stall;

	always_comb begin
		cmd           = '0;
		cmd.cfg_wr    = idle && cfg_valid;
		cmd.accept    = acc;
		cmd.calc_num  = (state_q == NUM);
		cmd.calc_den  = (state_q == DEN);
		cmd.div_start = (state_q == DIV_GO);
		cmd.walk_init = (state_q == WALK_INIT);
		cmd.walk      = (state_q == WALK) && !st.walk_done;
		cmd.fin       = (state_q == FIN) && st.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			case (state_q)
				IDLE: begin
					if (acc && st.warm_done) state_q <= NUM;
				end
				NUM:       state_q <= DEN;
				DEN:       state_q <= DIV_GO;
				DIV_GO:    state_q <= DIV_WAIT;
				DIV_WAIT: begin
					if (st.div_done) state_q <= WALK_INIT;
				end
				WALK_INIT: state_q <= WALK;
				WALK: begin
					if (st.walk_done) state_q <= FIN;
				end
				FIN: begin
					if (st.out_free) state_q <= IDLE;
				end
				default:   state_q <= IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/pb_dp.sv
// bar history, running sums, slope and band walk
module pb_dp import pb_pkg::*; #(
	parameter int MAX_PERIOD = PB_MAX_PERIOD
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pb_cmd_t                  cmd,
	output pb_stat_t                 st,
	input  logic [PERIOD_W-1:0]      cfg_data,
	input  logic [PRICE_W-1:0]       high_price,
	input  logic [PRICE_W-1:0]       low_price,
	input  logic [PRICE_W-1:0]       close_price,
	input  logic                     out_stall,
	output logic                     out_valid,
	output logic signed [BAND_W-1:0] upper_band,
	output logic signed [BAND_W-1:0] lower_band
);

	localparam int AW    = $clog2(MAX_PERIOD);
	localparam int N_W   = $clog2(MAX_PERIOD + 1);
	localparam int PW    = N_W + 1;
	localparam int CS_W  = PRICE_W + N_W;
	localparam int WS_W  = PRICE_W + 2 * N_W;
	localparam int T_W   = WS_W + 1;
	localparam int NUM_W = WS_W + 5;
	localparam int MAG_W = NUM_W - 1;
	localparam int DEN_W = 3 * N_W;
	localparam int BW    = (NUM_W + N_W + 1 > BAND_W + 1) ? NUM_W + N_W + 1 : BAND_W + 1;
	localparam logic signed [BW-1:0] SAT_HI =
		{{(BW - BAND_W + 1){1'b0}}, {(BAND_W - 1){1'b1}}};
	localparam logic signed [BW-1:0] SAT_LO = ~SAT_HI;

	pb_bar_t mem [MAX_PERIOD];
	pb_bar_t rd_q;

	logic [PERIOD_W-1:0]     period_q;
	logic [AW-1:0]           pos_q;
	logic [AW-1:0]           cur_pos_q;
	logic [N_W-1:0]          warmup_q;
	logic [CS_W-1:0]         cs_q;
	logic [WS_W-1:0]         ws_q;
	logic [PRICE_W-1:0]      hi_q;
	logic [PRICE_W-1:0]      lo_q;
	logic [PRICE_W-1:0]      cl_q;
	logic [2*N_W-1:0]        nsq_q;
	logic [DEN_W-1:0]        den_q;
	logic signed [NUM_W-1:0] num_q;
	logic [MAG_W-1:0]        mag_q;
	logic                    neg_q;
	logic signed [BW-1:0]    b_q;
	logic signed [BW-1:0]    jb_q;
	logic signed [BW-1:0]    jb_s1;
	logic                    last_s1;
	logic [N_W-1:0]          j_q;
	logic                    rd_pend_q;
	logic [PRICE_W-1:0]      close_old_q;
	logic signed [BW-1:0]    upper_q;
	logic signed [BW-1:0]    lower_q;
	logic                    out_valid_q;
	logic [BAND_W-1:0]       upper_out_q;
	logic [BAND_W-1:0]       lower_out_q;

	logic [N_W-1:0]          n_w;
	logic                    warm_done;
	logic [N_W-1:0]          mult;
	logic [CS_W-1:0]         prod;
	logic [T_W-1:0]          t_prod;
	logic [NUM_W-1:0]        ws_e;
	logic [NUM_W-1:0]        t_e;
	logic                    issue;
	logic [PW-1:0]           cur_e;
	logic [PW-1:0]           j_e;
	logic [AW-1:0]           rd_addr;
	logic                    div_done;
	logic [MAG_W-1:0]        quo;
	logic signed [BW-1:0]    quo_s;
	logic signed [BW-1:0]    b_new;
	logic signed [BW-1:0]    h_val;
	logic signed [BW-1:0]    l_val;

	function automatic logic [BAND_W-1:0] sat(input logic signed [BW-1:0] v);
		logic signed [BW-1:0] r;
		r = v;
		if (v > SAT_HI) r = SAT_HI;
		if (v < SAT_LO) r = SAT_LO;
		return r[BAND_W-1:0];
	endfunction

	always_comb begin
		if (period_q == '0) n_w = N_W'(1);
		else if (int'(period_q) > MAX_PERIOD) n_w = N_W'(MAX_PERIOD);
		else n_w = N_W'(period_q);
	end

	assign warm_done = (PW'(warmup_q) + PW'(1)) >= PW'(n_w);
	assign mult      = warm_done ? n_w : warmup_q + 1'b1;
	assign prod      = CS_W'(close_price) * CS_W'(mult);
	assign t_prod    = T_W'(cs_q) * T_W'(PW'(n_w) + PW'(1));
	assign ws_e      = NUM_W'(ws_q);
	assign t_e       = NUM_W'(t_prod);
	assign issue     = cmd.walk && (j_q < n_w);
	assign cur_e     = PW'(cur_pos_q);
	assign j_e       = PW'(j_q);
	assign rd_addr   = (cur_e >= j_e) ? AW'(cur_e - j_e) : AW'(cur_e + PW'(MAX_PERIOD) - j_e);
	assign quo_s     = $signed({{(BW - MAG_W){1'b0}}, quo});
	assign b_new     = (n_w == N_W'(1)) ? '0 : (neg_q ? -quo_s : quo_s);
	assign h_val     = $signed({{(BW - PRICE_W){1'b0}}, rd_q.high}) + jb_s1;
	assign l_val     = $signed({{(BW - PRICE_W){1'b0}}, rd_q.low}) + jb_s1;

	pb_div #(.NW(MAG_W), .DW(DEN_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mag_q),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (quo)
	);

	// history memory
	always_ff @(posedge clk) begin
		if (cmd.accept) mem[pos_q] <= '{high: high_price, low: low_price, close: close_price};
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RESET;
			pos_q       <= '0;
			warmup_q    <= '0;
			cs_q        <= '0;
			ws_q        <= '0;
			j_q         <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cfg_wr) begin
				period_q <= cfg_data;
				pos_q    <= '0;
				warmup_q <= '0;
				cs_q     <= '0;
				ws_q     <= '0;
			end else if (cmd.accept) begin
				pos_q <= (pos_q == AW'(MAX_PERIOD - 1)) ? '0 : pos_q + 1'b1;
				if (!warm_done) warmup_q <= warmup_q + 1'b1;
				ws_q <= ws_q + WS_W'(prod);
				cs_q <= cs_q + CS_W'(close_price);
			end else if (cmd.fin) begin
				ws_q <= ws_q - WS_W'(cs_q);
				cs_q <= cs_q - CS_W'(close_old_q);
			end
			if (cmd.walk_init) begin
				j_q       <= N_W'(1);
				rd_pend_q <= 1'b0;
			end else begin
				if (issue) j_q <= j_q + 1'b1;
				else if (cmd.cfg_wr) j_q <= '0;
				rd_pend_q <= issue;
			end
			if (cmd.fin) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			hi_q      <= high_price;
			lo_q      <= low_price;
			cl_q      <= close_price;
			cur_pos_q <= pos_q;
		end
		if (cmd.calc_num) begin
			num_q <= $signed(((ws_e << 3) + (ws_e << 2)) - ((t_e << 2) + (t_e << 1)));
			nsq_q <= (2*N_W)'(n_w) * (2*N_W)'(n_w);
		end
		if (cmd.calc_den) begin
			den_q <= DEN_W'(n_w) * DEN_W'(nsq_q - 1'b1);
			mag_q <= MAG_W'(num_q < 0 ? -num_q : num_q);
			neg_q <= (num_q < 0);
		end
		if (cmd.walk_init) begin
			b_q         <= b_new;
			jb_q        <= b_new;
			upper_q     <= $signed({{(BW - PRICE_W){1'b0}}, hi_q});
			lower_q     <= $signed({{(BW - PRICE_W){1'b0}}, lo_q});
			close_old_q <= cl_q;
		end else begin
			if (issue) begin
				jb_q    <= jb_q + b_q;
				jb_s1   <= jb_q;
				last_s1 <= (j_q == n_w - 1'b1);
			end
			if (rd_pend_q) begin
				if (h_val > upper_q) upper_q <= h_val;
				if (l_val < lower_q) lower_q <= l_val;
				if (last_s1) close_old_q <= rd_q.close;
			end
		end
		if (cmd.fin) begin
			upper_out_q <= sat(upper_q);
			lower_out_q <= sat(lower_q);
		end
	end

	assign st.warm_done = warm_done;
	assign st.div_done  = div_done;
	assign st.walk_done = (j_q >= n_w) && !rd_pend_q;
	assign st.out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign upper_band = $signed(upper_out_q);
	assign lower_band = $signed(lower_out_q);

`ifndef SYNTHESIS
	a_fin_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> st.walk_done)
		else $error("result loaded before band walk finished");
	a_warmup_bound: assert property (@(posedge clk) disable iff (!arst_n)
		warmup_q < n_w)
		else $error("warm-up count reached window length");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		j_q <= n_w)
		else $error("walk index beyond window");
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !div_done)
		else $error("divider done right after start");
`endif

endmodule

>>> rtl/core/projection_bands_top.sv
// top level of the projection bands indicator
// warm-up bars are accepted while idle and give no result
// a result bar goes through the slope sums, the bit-serial slope divider and the
// one-bar-per-cycle history walk
// one bar in flight at a time; a finished result waits in the output register
// reset: asynchronous, clears sums, ring position, warm-up count, period to 14
module projection_bands_top import pb_pkg::*; #(
	parameter int MAX_PERIOD = PB_MAX_PERIOD
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// bar input channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [PRICE_W-1:0]       high_price,
	input  logic [PRICE_W-1:0]       low_price,
	input  logic [PRICE_W-1:0]       close_price,
	// band output channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [BAND_W-1:0] upper_band,
	output logic signed [BAND_W-1:0] lower_band,
	// period register write channel, one beat per write
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [PERIOD_W-1:0]      period_length
);

	// command and status between sequencer and datapath
	pb_cmd_t  cmd;
	pb_stat_t st;

	// sequencer: accepts a bar and, once warm-up is done, runs slope, division and band walk
	pb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cfg_valid (cfg_valid),
		.st        (st),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	// datapath: history ring, running sums, divider, walk and output register
	pb_dp #(.MAX_PERIOD(MAX_PERIOD)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg_data    (period_length),
		.high_price  (high_price),
		.low_price   (low_price),
		.close_price (close_price),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.upper_band  (upper_band),
		.lower_band  (lower_band)
	);

endmodule
